### rtl/core/nearest_point_search_2d_unit_defines.svh
// Assertion macros for the nearest point search unit.
// Included by the checker; no other dependencies.
`ifndef NEAREST_POINT_SEARCH_2D_UNIT_DEFINES_SVH
`define NEAREST_POINT_SEARCH_2D_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define NPS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");

// Next-cycle implication, sampled on clk, off during reset.
`define NPS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");

`endif

### rtl/core/nps2d_pkg.sv
// Shared constants, command codes and request/result types of the
// nearest point search unit. No dependencies.
package nps2d_pkg;

  localparam int REF_DEPTH = 1024;
  localparam int COORD_W   = 32;
  localparam int IDX_W     = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int CNT_W     = $clog2(REF_DEPTH + 1);
  localparam int MEM_W     = 2 * COORD_W;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int DIST_W    = 2 * COORD_W + 1;
  localparam int MATCH_W   = 10;
  localparam int QIDX_W    = 16;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_CLEAR = 2'd0;
  localparam cmd_t CMD_LOAD  = 2'd1;
  localparam cmd_t CMD_QUERY = 2'd2;

  typedef struct packed {
    cmd_t               command;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
  } nps_in_t;

  typedef struct packed {
    logic [QIDX_W-1:0]  query_index;
    logic [MATCH_W-1:0] match_index;
    logic               found;
  } nps_out_t;

endpackage

### rtl/core/nearest_point_search_2d_unit.sv
// Brute-force 2D nearest point search: reference store, scan pipeline, result.
// Depends on nps2d_pkg.
//
// Usage:
// - Request channel: a request (in_req) is taken at a rising edge with start
//   high and busy low. command selects clear, load or query; code 3 is
//   dropped. Coordinates are signed Q16.16.
// - Clear and load never raise busy. A load past the
//   store capacity is dropped. Neither gives a result.
// - A query raises busy and scans every stored reference point, one per
//   cycle through the single read port of the reference memory. The result
//   strobe out_valid comes once the scan pipeline has drained (an empty
//   store skips the scan); busy falls in the same cycle.
// - Result channel: out_valid is high for one cycle with out_res; the
//   receiver cannot stall and must take it then.
// - Reset (rst_n low, synchronous) empties the store and zeroes the query
//   counter; memory contents are left as they are.
module nearest_point_search_2d_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  nps2d_pkg::nps_in_t  in_req,
  output logic               out_valid,
  output nps2d_pkg::nps_out_t out_res
);
  import nps2d_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  // Reference store: x in the low half, y in the high half of each entry.
  logic [MEM_W-1:0] mem [REF_DEPTH];

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  ref_count_r;
  logic [QIDX_W-1:0] qcnt_r;
  logic [CNT_W-1:0]  scan_r;

  // query point, low COORD_W bits of each coordinate
  logic [COORD_W-1:0] px_r, py_r;

  // pipeline: memory read, difference, square, compare
  logic              v1_r, v2_r, v3_r;
  logic [MEM_W-1:0]  rdata_r;
  logic [IDX_W-1:0]  idx1_r, idx2_r, idx3_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r;
  logic [SQ_W-1:0]   sqx_r, sqy_r;

  logic [DIST_W-1:0] best_dist_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic              have_r;

  logic              out_valid_r;
  nps_out_t          out_res_r;

  logic              accept;
  logic              issue;
  logic              last_issue;
  logic              pipe_empty;
  logic              emit;
  logic [COORD_W-1:0] qx, qy;
  logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;
  logic [DIST_W-1:0] cand_dist;
  logic              better;
  logic [IDX_W+MATCH_W-1:0] midx_ext;

  assign accept     = start && (state_r == ST_IDLE);
  assign issue      = (state_r == ST_SCAN);
  assign last_issue = (scan_r + CNT_W'(1)) == ref_count_r;
  assign pipe_empty = !v1_r && !v2_r && !v3_r;
  assign emit       = (state_r == ST_DRAIN) && pipe_empty;

  assign qx = rdata_r[COORD_W-1:0];
  assign qy = rdata_r[MEM_W-1:COORD_W];

  assign sqx_full = dx_r * dx_r;
  assign sqy_full = dy_r * dy_r;

  assign cand_dist = {1'b0, sqx_r} + {1'b0, sqy_r};
  // strict less-than keeps the lowest index on ties
  assign better = v3_r && (!have_r || (cand_dist < best_dist_r));

  assign midx_ext = (IDX_W + MATCH_W)'(best_idx_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_req.command == CMD_QUERY)) begin
          // empty store goes straight to the result
          state_nxt = (ref_count_r == '0) ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ref_count_r <= '0;
      qcnt_r      <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      v1_r        <= issue;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= emit;
      if (accept && (in_req.command == CMD_CLEAR)) begin
        ref_count_r <= '0;
        qcnt_r      <= '0;
      end else if (accept && (in_req.command == CMD_LOAD) &&
                   (ref_count_r < CNT_W'(REF_DEPTH))) begin
        ref_count_r <= ref_count_r + CNT_W'(1);
      end
      if (emit) begin
        qcnt_r <= qcnt_r + QIDX_W'(1);
      end
    end
  end

  // reference memory: one write port (load), one registered read port (scan)
  always_ff @(posedge clk) begin
    if (accept && (in_req.command == CMD_LOAD) &&
        (ref_count_r < CNT_W'(REF_DEPTH))) begin
      mem[ref_count_r[IDX_W-1:0]] <= {in_req.y_coord[COORD_W-1:0],
                                      in_req.x_coord[COORD_W-1:0]};
    end
    rdata_r <= mem[scan_r[IDX_W-1:0]];
  end

  // scan datapath
  always_ff @(posedge clk) begin
    idx1_r <= scan_r[IDX_W-1:0];
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    dx_r   <= $signed({px_r[COORD_W-1], px_r}) - $signed({qx[COORD_W-1], qx});
    dy_r   <= $signed({py_r[COORD_W-1], py_r}) - $signed({qy[COORD_W-1], qy});
    sqx_r  <= sqx_full[SQ_W-1:0];
    sqy_r  <= sqy_full[SQ_W-1:0];

    if (accept && (in_req.command == CMD_QUERY)) begin
      px_r       <= in_req.x_coord[COORD_W-1:0];
      py_r       <= in_req.y_coord[COORD_W-1:0];
      scan_r     <= '0;
      have_r     <= 1'b0;
      best_idx_r <= '0;
    end else begin
      if (issue) begin
        scan_r <= scan_r + CNT_W'(1);
      end
      if (better) begin
        have_r      <= 1'b1;
        best_dist_r <= cand_dist;
        best_idx_r  <= idx3_r;
      end
    end

    if (emit) begin
      out_res_r.query_index <= qcnt_r;
      out_res_r.match_index <= midx_ext[MATCH_W-1:0];
      out_res_r.found       <= have_r;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

### rtl/core/nps2d_checker.sv
// Port-level checks for the nearest point search unit, bound to the top.
// Depends on nps2d_pkg and nearest_point_search_2d_unit_defines.svh.
`include "nearest_point_search_2d_unit_defines.svh"

module nps2d_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input nps2d_pkg::nps_in_t  in_req,
  input logic                out_valid,
  input nps2d_pkg::nps_out_t out_res
);
  import nps2d_pkg::*;

  // a query always occupies the unit
  `NPS_ASSERT_NXT(a_query_busy, clk, rst_n, start && !busy && (in_req.command == CMD_QUERY), busy)
  // a result only ends a busy period
  `NPS_ASSERT_IMP(a_res_after_busy, clk, rst_n, out_valid, $past(busy) && !busy)
  // one result per query, never two in a row
  `NPS_ASSERT_NXT(a_res_single, clk, rst_n, out_valid, !out_valid)
  // empty store reports index zero
  `NPS_ASSERT_IMP(a_empty_idx, clk, rst_n, out_valid && !out_res.found, out_res.match_index == '0)

endmodule

bind nearest_point_search_2d_unit nps2d_checker u_nps2d_checker (.*);
